// ===== hw/rtl/fti_pkg.sv =====
// Shared constants for the fisher transform indicator.
// Depends on nothing.
package fti_pkg;
	localparam int unsigned QCoefNew = 10813;
	localparam int unsigned QCoefOld = 21955;
	localparam int unsigned QSnapAt  = 32440;
	localparam int unsigned QSnapTo  = 32735;
	localparam logic [27:0] Ln2Q28   = 28'd186065280;
	localparam int          FisherMax = 524287;
	localparam int          FisherMin = -524288;
	localparam logic [8:0]  WindowReset = 9'd10;
	localparam int          PriceBits = 32;
endpackage

// ===== hw/rtl/fisher_transform_indicator.sv =====
// Fisher transform indicator over a trailing window of bar medians.
// Channels: input bar (bar_high, bar_low, restart) with in_valid/in_ready;
// result (fisher_out, out_valid) with res_valid/res_ready; config write
// cfg_valid/cfg_ready carrying window_length.
// Each bar median is written to a single-port-style synchronous ring memory;
// min and max are then found by reading the window back one entry a cycle.
// Per bar: the write and scan, the divide, the two log2 evaluations and the
// scale and finish steps run in turn before the result shows; a flat window
// skips the divide. One bar at a time: a new bar is taken only after the
// result is accepted.
// During warm-up the WRITE state goes straight to the result (fisher_out 0, out_valid 0), with no scan.
// Reset: pointer, bar count, smoothed value and fisher line clear, window
// length returns to 10. Ring contents are not cleared: only entries written
// since reset or restart are ever read.
// A stalled receiver holds the result register; no new bar is taken until
// the result is accepted.
// Depends on fti_pkg, fti_div, fti_log2.
module fisher_transform_indicator #(
	parameter int MAX_WINDOW = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [31:0]           bar_high,
	input  logic [31:0]           bar_low,
	input  logic                  restart,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic signed [19:0]    fisher_out,
	output logic                  out_valid,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [8:0]            window_length
);
	localparam int AW = $clog2(MAX_WINDOW);
	localparam int MW = fti_pkg::PriceBits + 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);

	typedef enum logic [3:0] {
		IDLE, WRITE, SCAN, SCAN_LAST, DIV_START, DIV_WAIT, SMOOTH,
		LOG_P, LOG_P_WAIT, LOG_M, LOG_M_WAIT, SCALE, FINISH, OUT
	} st_t;

	st_t st_q;
	logic [MW-1:0] ring_q [2**AW];
	logic [MW-1:0] rd_q;
	logic [AW-1:0] ptr_q, rd_addr_q;
	logic [CW-1:0] seen_q, cnt_q;
	logic [8:0]    win_q;
	logic [CW-1:0] w_eff;
	logic [MW-1:0] med_q, hi_q, lo_q;
	logic signed [15:0] sp_q;
	logic signed [20:0] fl_q;
	logic signed [16:0] p_q;
	logic [14:0]   abs_q;
	logic          neg_q;
	logic [33:0]   lp_q;
	logic [33:0]   d_q;
	logic [61:0]   r_q;

	// window clamp
	always_comb begin
		if (win_q == 9'd0) w_eff = CW'(1);
		else if ({23'd0, win_q} > MAX_WINDOW) w_eff = CW'(MAX_WINDOW);
		else w_eff = CW'(win_q);
	end

	// divider operands: shift range below 2^32
	logic [MW-1:0] range_w, off_w;
	logic [31:0]   den_w;
	logic [47:0]   num_w;
	always_comb begin
		range_w = hi_q - lo_q;
		off_w   = med_q - lo_q;
		den_w   = 32'(range_w);
		num_w   = 48'({off_w, 16'd0});
		for (int s = 0; s < MW; s++) begin
			if ((range_w >> s) < (64'd1 << 32) && ((s == 0) || ((range_w >> (s - 1)) >= (64'd1 << 32)))) begin
				den_w = 32'(range_w >> s);
				num_w = 48'({off_w >> s, 16'd0});
			end
		end
	end

	logic div_start, div_done;
	logic [47:0] quot;
	fti_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num_w), .den(den_w), .done(div_done), .quot(quot)
	);

	logic log_start, log_done;
	logic [15:0] log_x;
	logic [33:0] log_res;
	fti_log2 u_log (
		.clk(clk), .arst_n(arst_n), .start(log_start), .x(log_x),
		.done(log_done), .result(log_res)
	);

	assign div_start = (st_q == DIV_START);
	assign log_start = (st_q == LOG_P) || (st_q == LOG_M);
	assign log_x     = (st_q == LOG_P) ? 16'(17'd32768 + {2'd0, abs_q})
	                                   : 16'(17'd32768 - {2'd0, abs_q});
	assign in_ready  = (st_q == IDLE);
	assign cfg_ready = (st_q == IDLE) && !in_valid;
	assign res_valid = (st_q == OUT);

	// smoothing
	localparam logic signed [33:0] QCOEF_NEW_S = 34'(fti_pkg::QCoefNew);
	localparam logic signed [33:0] QCOEF_OLD_S = 34'(fti_pkg::QCoefOld);
	logic signed [33:0] s_sum;
	logic signed [18:0] s_sh;
	logic signed [15:0] s_sat;
	assign s_sum = 34'(p_q) * 34'(QCOEF_NEW_S) + 34'(sp_q) * 34'(QCOEF_OLD_S) + 34'sd16384;
	assign s_sh = 19'(s_sum >>> 15);
	always_comb begin
		if (s_sh > $signed(19'(fti_pkg::QSnapAt))) s_sat = 16'(fti_pkg::QSnapTo);
		else if (s_sh < -$signed(19'(fti_pkg::QSnapAt))) s_sat = -16'(fti_pkg::QSnapTo);
		else s_sat = 16'(s_sh);
	end

	// final sum
	logic [19:0] r_mag;
	logic signed [22:0] f_sum;
	logic signed [19:0] f_sat;
	assign r_mag = 20'((r_q + (62'd1 << 42)) >> 43);
	assign f_sum = (neg_q ? -23'($signed({3'd0, r_mag})) : 23'($signed({3'd0, r_mag})))
	               + 23'(fl_q >>> 1);
	always_comb begin
		if (f_sum > 23'(fti_pkg::FisherMax)) f_sat = 20'(fti_pkg::FisherMax);
		else if (f_sum < 23'(fti_pkg::FisherMin)) f_sat = 20'(fti_pkg::FisherMin);
		else f_sat = 20'(f_sum);
	end

	always_ff @(posedge clk) begin
		if (st_q == WRITE) ring_q[ptr_q] <= med_q;
		rd_q <= ring_q[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= IDLE;
			ptr_q      <= '0;
			seen_q     <= '0;
			sp_q       <= '0;
			fl_q       <= '0;
			win_q      <= fti_pkg::WindowReset;
			fisher_out <= '0;
			out_valid  <= 1'b0;
			rd_addr_q  <= '0;
			cnt_q      <= '0;
		end else begin
			unique case (st_q)
				IDLE: begin
					if (cfg_valid && cfg_ready) win_q <= window_length;
					if (in_valid) begin
						med_q <= MW'({1'b0, bar_high[fti_pkg::PriceBits-1:0]})
						       + MW'({1'b0, bar_low[fti_pkg::PriceBits-1:0]});
						if (restart) begin
							sp_q   <= '0;
							fl_q   <= '0;
							seen_q <= '0;
						end else if (seen_q > w_eff) begin
							seen_q <= w_eff;
						end
						st_q <= WRITE;
					end
				end
				WRITE: begin
					ptr_q <= ptr_q + AW'(1);
					hi_q  <= med_q;
					lo_q  <= med_q;
					rd_addr_q <= ptr_q;
					cnt_q <= w_eff;
					if (seen_q + CW'(1) < w_eff) begin
						seen_q <= seen_q + CW'(1);
						fisher_out <= '0;
						out_valid  <= 1'b0;
						st_q <= OUT;
					end else begin
						seen_q <= w_eff;
						st_q <= SCAN;
					end
				end
				SCAN: begin
					rd_addr_q <= rd_addr_q - AW'(1);
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q != w_eff) begin
						if (rd_q > hi_q) hi_q <= rd_q;
						if (rd_q < lo_q) lo_q <= rd_q;
					end
					if (cnt_q == CW'(1)) st_q <= SCAN_LAST;
				end
				SCAN_LAST: begin
					if (rd_q > hi_q) hi_q <= rd_q;
					if (rd_q < lo_q) lo_q <= rd_q;
					st_q <= DIV_START;
				end
				DIV_START: begin
					if (hi_q == lo_q) begin
						p_q  <= -17'sd32768;
						st_q <= SMOOTH;
					end else begin
						st_q <= DIV_WAIT;
					end
				end
				DIV_WAIT: if (div_done) begin
					p_q  <= 17'($signed({1'b0, quot[16:0]}) - 18'sd32768);
					st_q <= SMOOTH;
				end
				SMOOTH: begin
					sp_q  <= s_sat;
					neg_q <= s_sat[15];
					abs_q <= s_sat[15] ? 15'(-s_sat) : 15'(s_sat);
					st_q  <= LOG_P;
				end
				LOG_P: st_q <= LOG_P_WAIT;
				LOG_P_WAIT: if (log_done) begin
					lp_q <= log_res;
					st_q <= LOG_M;
				end
				LOG_M: st_q <= LOG_M_WAIT;
				LOG_M_WAIT: if (log_done) begin
					d_q  <= lp_q - log_res;
					st_q <= SCALE;
				end
				SCALE: begin
					r_q  <= 62'(d_q) * 62'(fti_pkg::Ln2Q28);
					st_q <= FINISH;
				end
				FINISH: begin
					fl_q       <= 21'(f_sat);
					fisher_out <= f_sat;
					out_valid  <= 1'b1;
					st_q       <= OUT;
				end
				OUT: if (res_ready) st_q <= IDLE;
				default: st_q <= IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/fti_div.sv =====
// Restoring divider, one quotient bit a cycle: num / den, 48-bit numerator.
// Depends on nothing.
module fti_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [47:0] quot
);
	logic [32:0] rem_q;
	logic [47:0] n_q;
	logic [31:0] d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [33:0] diff;

	assign trial = {rem_q[31:0], n_q[47]};
	assign diff  = {1'b0, trial} - {2'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			rem_q <= '0;
			quot  <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[46:0], 1'b0};
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				quot  <= {quot[46:0], 1'b1};
			end else begin
				rem_q <= trial;
				quot  <= {quot[46:0], 1'b0};
			end
		end
	end
endmodule

// ===== hw/rtl/fti_log2.sv =====
// Sequential log2 with 30 fraction bits by repeated squaring, one bit per squaring.
// The 31x31 square is split in two 16-bit-row partial products, MUL_LO then MUL_HI.
// Depends on nothing.
module fti_log2 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] x,
	output logic        done,
	output logic [33:0] result
);
	typedef enum logic [1:0] {IDLE, MUL_LO, MUL_HI} st_t;
	st_t         st_q;
	logic [31:0] m_q;
	logic [47:0] plo_q;
	logic [4:0]  k_q;
	logic [3:0]  ip;
	logic [29:0] frac_q;
	logic [3:0]  ip_q;
	logic [62:0] sq;
	logic [31:0] sq_s;

	always_comb begin
		ip = 4'd0;
		for (int i = 1; i < 16; i++) begin
			if (x[i]) ip = 4'(i);
		end
	end

	assign sq   = {15'd0, plo_q} + ({15'd0, 48'(m_q[31:16]) * 48'(m_q)} << 16);
	assign sq_s = sq[61:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				IDLE: if (start) st_q <= MUL_LO;
				MUL_LO: st_q <= MUL_HI;
				MUL_HI: begin
					if (k_q == 5'd0) begin
						st_q <= IDLE;
						done <= 1'b1;
					end else begin
						st_q <= MUL_LO;
					end
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			IDLE: if (start) begin
				m_q    <= 32'({x, 30'd0} >> ip);
				ip_q   <= ip;
				frac_q <= '0;
				k_q    <= 5'd29;
			end
			MUL_LO: plo_q <= m_q[15:0] * m_q;
			MUL_HI: begin
				k_q <= k_q - 5'd1;
				if (sq_s[31]) begin
					m_q    <= {1'b0, sq_s[31:1]};
					frac_q <= frac_q | (30'd1 << k_q);
				end else begin
					m_q <= sq_s;
				end
			end
			default: ;
		endcase
	end

	assign result = {ip_q, frac_q};
endmodule

// ===== test/fisher_transform_indicator_test.sv =====
// Testbench for fisher_transform_indicator: directed bars, then random price walks
// under several window lengths, checked against a built-in fixed-point predictor.
// Depends on fti_pkg and the fisher_transform_indicator RTL.
module fisher_transform_indicator_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MaxWindow = 256;

	typedef struct {
		logic signed [19:0] fisher;
		logic               valid;
	} fisher_result_t;

	typedef struct {
		logic [31:0]        high;
		logic [31:0]        low;
		logic               restart;
		bit                 typed;
		logic signed [19:0] fisher;
		logic               valid;
	} bar_row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, restart;
	logic [31:0] bar_high, bar_low;
	logic res_valid, res_ready, out_valid;
	logic signed [19:0] fisher_out;
	logic cfg_valid, cfg_ready;
	logic [8:0] window_length;

	fisher_transform_indicator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.bar_high(bar_high), .bar_low(bar_low), .restart(restart),
		.res_valid(res_valid), .res_ready(res_ready),
		.fisher_out(fisher_out), .out_valid(out_valid),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.window_length(window_length)
	);

	// predictor state
	logic [32:0] median_hist [MaxWindow];
	int unsigned hist_ptr, bar_count, window_cfg;
	longint      smooth_q15, fisher_q16;

	fisher_result_t fisher_queue[$];
	int error_count;
	bit rx_quiet;

	function automatic longint unsigned log2_frac30(int unsigned x);
		int unsigned ip;
		longint unsigned m, frac;
		ip = 0;
		frac = 0;
		while (ip < 31 && (x >> (ip + 1)) != 0)
			ip++;
		m = longint'(x) << (30 - ip);
		for (int k = 29; k >= 0; k--) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac |= 64'd1 << k;
			end
		end
		return (longint'(ip) << 30) | frac;
	endfunction

	function automatic longint atanh_q16(longint v);
		longint unsigned a, d, r;
		a = v < 0 ? -v : v;
		if (a > 32767)
			a = 32767;
		d = log2_frac30(32768 + a) - log2_frac30(32768 - a);
		r = (d * longint'(fti_pkg::Ln2Q28) + (64'd1 << 42)) >> 43;
		return v < 0 ? -longint'(r) : longint'(r);
	endfunction

	function automatic fisher_result_t fisher_predict(logic [31:0] hi_p, logic [31:0] lo_p,
			logic rst);
		fisher_result_t res;
		logic [32:0] med;
		longint unsigned top, bot, off, span, q;
		int unsigned w, idx;
		longint p, s, f;
		med = {1'b0, hi_p} + {1'b0, lo_p};
		w = window_cfg == 0 ? 1 : (window_cfg > MaxWindow ? MaxWindow : window_cfg);
		if (rst) begin
			smooth_q15 = 0;
			fisher_q16 = 0;
			bar_count = 0;
		end
		median_hist[hist_ptr] = med;
		hist_ptr = (hist_ptr + 1) % MaxWindow;
		if (bar_count < w)
			bar_count++;
		if (bar_count > w)
			bar_count = w;
		if (bar_count < w) begin
			res.fisher = '0;
			res.valid = 1'b0;
			return res;
		end
		top = med;
		bot = med;
		idx = hist_ptr;
		for (int k = 0; k < w; k++) begin
			idx = idx == 0 ? MaxWindow - 1 : idx - 1;
			if (median_hist[idx] > top)
				top = median_hist[idx];
			if (median_hist[idx] < bot)
				bot = median_hist[idx];
		end
		span = top - bot;
		if (span == 0) begin
			p = -32768;
		end else begin
			off = med - bot;
			while ((span >> 32) != 0) begin
				span = span >> 1;
				off = off >> 1;
			end
			q = (off << 16) / span;
			p = longint'(q) - 32768;
		end
		s = (longint'(fti_pkg::QCoefNew) * p + longint'(fti_pkg::QCoefOld) * smooth_q15
			+ 16384) >>> 15;
		if (s > longint'(fti_pkg::QSnapAt))
			s = fti_pkg::QSnapTo;
		if (s < -longint'(fti_pkg::QSnapAt))
			s = -longint'(fti_pkg::QSnapTo);
		smooth_q15 = s;
		f = atanh_q16(s) + (fisher_q16 >>> 1);
		if (f > fti_pkg::FisherMax)
			f = fti_pkg::FisherMax;
		if (f < fti_pkg::FisherMin)
			f = fti_pkg::FisherMin;
		fisher_q16 = f;
		res.fisher = f[19:0];
		res.valid = 1'b1;
		return res;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// result side
	initial begin
		int stall;
		fisher_result_t want;
		stall = 0;
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid && res_ready) begin
				if (fisher_queue.size() == 0) begin
					$error("unexpected item: fisher_out %0d out_valid %0b", fisher_out, out_valid);
					error_count++;
				end else begin
					want = fisher_queue.pop_front();
					if (fisher_out !== want.fisher) begin
						$error("fisher_out expected %0d actual %0d", want.fisher, fisher_out);
						error_count++;
					end
					if (out_valid !== want.valid) begin
						$error("out_valid expected %0b actual %0b", want.valid, out_valid);
						error_count++;
					end
				end
			end
			if (stall > 0 && !rx_quiet) begin
				stall--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
				case ($urandom_range(0, 19))
					0, 1, 2, 3: stall = $urandom_range(1, 3);
					4:          stall = $urandom_range(20, 80);
					default:    stall = 0;
				endcase
			end
		end
	end

	task automatic send_bar(logic [31:0] hi_p, logic [31:0] lo_p, logic rst, bit quiet,
			bit typed = 0, logic signed [19:0] t_fisher = 0, logic t_valid = 0);
		int gap;
		fisher_result_t res;
		gap = 0;
		if (!quiet) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
				5:             gap = $urandom_range(20, 60);
				default:       gap = 0;
			endcase
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		bar_high <= hi_p;
		bar_low <= lo_p;
		restart <= rst;
		do @(posedge clk); while (!in_ready);
		res = fisher_predict(hi_p, lo_p, rst);
		if (typed) begin
			res.fisher = t_fisher;
			res.valid = t_valid;
		end
		fisher_queue.push_back(res);
	endtask

	task automatic drain_and_config(logic [8:0] w);
		in_valid <= 1'b0;
		while (fisher_queue.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		window_length <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		window_cfg = w;
	endtask

	bar_row_t directed [] = '{
		'{32'h0, 32'h0, 1'b0, 1, 20'sd0, 1'b0},
		'{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1, 20'sd0, 1'b0},
		'{32'hFFFFFFFF, 32'h0, 1'b0, 1, 20'sd0, 1'b0},
		'{32'h0, 32'hFFFFFFFF, 1'b0, 1, 20'sd0, 1'b0},
		'{32'h1, 32'h0, 1'b0, 1, 20'sd0, 1'b0},
		'{32'h80000000, 32'h7FFFFFFF, 1'b0, 1, 20'sd0, 1'b0},
		'{32'h55555555, 32'hAAAAAAAA, 1'b0, 1, 20'sd0, 1'b0},
		'{32'h100, 32'h80, 1'b0, 1, 20'sd0, 1'b0},
		'{32'h200, 32'h100, 1'b0, 1, 20'sd0, 1'b0},
		'{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 0, 20'sd0, 1'b0},
		'{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 0, 20'sd0, 1'b0},
		'{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 0, 20'sd0, 1'b0},
		'{32'h0, 32'h0, 1'b0, 0, 20'sd0, 1'b0},
		'{32'h0, 32'h0, 1'b0, 0, 20'sd0, 1'b0},
		'{32'h0, 32'h0, 1'b0, 0, 20'sd0, 1'b0},
		'{32'h1234, 32'h1000, 1'b1, 1, 20'sd0, 1'b0},
		'{32'h1234, 32'h1000, 1'b0, 1, 20'sd0, 1'b0}
	};

	initial begin
		logic [8:0] windows [] = '{9'd1, 9'd0, 9'd2, 9'd3, 9'd20, 9'd256, 9'd511, 9'd300,
			9'd5, 9'd12};
		int counts [] = '{20, 40, 50, 40, 80, 290, 20, 20, 60, 80};
		int unsigned base, spread;
		logic [31:0] hi_p, lo_p;
		bit quiet;
		arst_n = 1'b0;
		in_valid = 1'b0;
		bar_high = '0;
		bar_low = '0;
		restart = 1'b0;
		cfg_valid = 1'b0;
		window_length = fti_pkg::WindowReset;
		rx_quiet = 1'b0;
		error_count = 0;
		hist_ptr = 0;
		bar_count = 0;
		smooth_q15 = 0;
		fisher_q16 = 0;
		window_cfg = fti_pkg::WindowReset;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_bar(directed[i].high, directed[i].low, directed[i].restart, 0,
				directed[i].typed, directed[i].fisher, directed[i].valid);

		base = 32'h4000_0000;
		foreach (windows[ph]) begin
			drain_and_config(windows[ph]);
			quiet = (ph == 3);
			rx_quiet = quiet;
			for (int n = 0; n < counts[ph]; n++) begin
				case ($urandom_range(0, 9))
					0: begin
						hi_p = $urandom;
						lo_p = $urandom;
					end
					1: begin
						hi_p = base;
						lo_p = base;
					end
					default: begin
						spread = $urandom_range(0, 15) == 0 ? $urandom : $urandom_range(0, 4000);
						base = base + $urandom_range(0, 2000) - 1000;
						hi_p = base + spread;
						lo_p = base;
					end
				endcase
				send_bar(hi_p, lo_p, $urandom_range(0, 39) == 0, quiet);
			end
		end
		in_valid <= 1'b0;
		rx_quiet = 1'b0;
		while (fisher_queue.size() != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
		if (error_count == 0 && fisher_queue.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
